[rtl/tsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, character codes and a helper for the tab stop retabulator.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int MAX_RUN_DEF     = 63;
  localparam int COLUMN_BITS_DEF = 16;

  localparam int STOP_W = 7;  // tab stop register width
  localparam int REM_W  = 6;  // remainder of column by a stop (< 64)
  localparam int CHAR_W = 7;

  // register indexes
  localparam logic REG_OLD_STOP = 1'b0;
  localparam logic REG_NEW_STOP = 1'b1;

  // scanner modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_QUOTE  = 2'd1;
  localparam logic [1:0] MODE_BLANK  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB = 7'h09;
  localparam logic [CHAR_W-1:0] CH_NL  = 7'h0a;
  localparam logic [CHAR_W-1:0] CH_SP  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_DQ  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_SQ  = 7'h27;
  localparam logic [CHAR_W-1:0] CH_BS  = 7'h5c;

  typedef struct packed {
    logic              start;
    logic [STOP_W-1:0] divisor;
  } tsr_mod_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } tsr_mod_rsp_t;

  // stop register value 0 acts as 1, anything above 64 as 64
  function automatic logic [STOP_W-1:0] stop_clamp(input logic [STOP_W-1:0] v);
    logic [STOP_W-1:0] r;
    r = v;
    if (v == '0) r = STOP_W'(1);
    else if (v > STOP_W'(64)) r = STOP_W'(64);
    return r;
  endfunction

endpackage

[rtl/tsr_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_mod
// Bit-serial restoring remainder: column modulo tab stop, one bit a cycle.
// ----------------------------------------------------------------------------
module tsr_mod
  import tsr_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tsr_mod_req_t           req,
  input  logic [COLUMN_BITS-1:0] dividend,
  output tsr_mod_rsp_t           rsp
);

  localparam int CNT_W = $clog2(COLUMN_BITS + 1);

  logic [COLUMN_BITS-1:0] shift_r, shift_nxt;
  logic [STOP_W-1:0]      div_r, div_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;
  logic [REM_W:0]         part;

  always_comb begin
    shift_nxt = shift_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    part      = {rem_r, shift_r[COLUMN_BITS-1]};
    if (req.start) begin
      shift_nxt = dividend;
      div_nxt   = req.divisor;
      rem_nxt   = '0;
      cnt_nxt   = CNT_W'(COLUMN_BITS);
      run_nxt   = 1'b1;
    end else if (run_r) begin
      // partial remainder stays below the divisor, so one subtract suffices
      if (part >= div_r) rem_nxt = REM_W'(part - div_r);
      else rem_nxt = part[REM_W-1:0];
      shift_nxt = shift_r << 1;
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

[rtl/tab_stop_retabulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_stop_retabulator
// Re-expresses runs of blanks in a 7-bit text stream for a new tab stop.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata / tuser / tlast               | note
//  --------+-----+-------------------------------------+----------------------
//  in_     | in  | tdata[7:0] in_byte                  | bit 7 ignored
//  out_    | out | tdata[6:0] out_char, tlast run_last | several per input
//  cfg_    | in  | addr 0 old_tab_stop, 1 new_tab_stop | write only
//
//  Flow: one input transaction at a time; in_tready is high only while the
//  sequencer is idle. Every tab stop distance goes through the shared
//  bit-serial remainder unit: a tab in quote mode or in a blank run costs one
//  pass, and an emitted run of more than one column costs one pass per tab,
//  one more when spaces follow the tabs.
//  Reset: synchronous, active low; no clearing pass.
//  Stalls: results sit in one output register; the sequencer waits on it
//  while out_tready is low.
//
module tab_stop_retabulator
  import tsr_pkg::*;
#(
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] in_byte
  // output stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [6:0] out_char, [7] zero
  output logic              out_tlast,   // run_last
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [STOP_W-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;  // waiting on remainder unit
  localparam logic [2:0] S_BLANK = 3'd2;  // add blank width to run
  localparam logic [2:0] S_RUN   = 3'd3;  // start of run emission
  localparam logic [2:0] S_TAB   = 3'd4;  // emit one new-stop tab
  localparam logic [2:0] S_SPACE = 3'd5;  // emit spaces
  localparam logic [2:0] S_CHAR  = 3'd6;  // emit the character itself

  // what a remainder pass is for
  localparam logic [1:0] P_QTAB = 2'd0;   // tab inside quotes
  localparam logic [1:0] P_BTAB = 2'd1;   // tab added to blank run
  localparam logic [1:0] P_RUN  = 2'd2;   // next tab of emitted run

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             purp_r, purp_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [5:0]             pend_r, pend_nxt;
  logic [CHAR_W-1:0]      qchar_r, qchar_nxt;
  logic                   esc_r, esc_nxt;
  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic                   has_char_r, has_char_nxt;
  logic                   upd_col_r, upd_col_nxt;
  logic [STOP_W-1:0]      b_r, b_nxt;   // run columns left to emit
  logic [STOP_W-1:0]      a_r, a_nxt;   // width of incoming blank
  logic [5:0]             p_r, p_nxt;   // pending run before this blank
  logic [STOP_W-1:0]      j_r, j_nxt;   // distance to next new stop
  logic [STOP_W-1:0]      old_r, new_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [STOP_W-1:0]      os, nt;
  logic [STOP_W-1:0]      t_sum, e_run;
  logic [CHAR_W-1:0]      c_in;
  logic [1:0]             m_eff;
  logic [5:0]             p_in;
  logic                   accept, push_ok, is_quote;
  logic [COLUMN_BITS-1:0] mod_dividend;
  tsr_mod_req_t           mod_req;
  tsr_mod_rsp_t           mod_rsp;

  assign os      = stop_clamp(old_r);
  assign nt      = stop_clamp(new_r);
  assign accept  = in_tvalid && in_tready;
  assign push_ok = !out_valid_r || out_tready;
  assign c_in    = in_tdata[CHAR_W-1:0];
  assign m_eff   = (mode_r == MODE_QUOTE || mode_r == MODE_BLANK) ? mode_r : MODE_NORMAL;
  assign p_in    = (m_eff == MODE_BLANK) ? pend_r : 6'd0;
  assign is_quote = (c_in == CH_SQ) || (c_in == CH_DQ);
  assign t_sum   = {1'b0, p_r} + a_r;
  assign e_run   = (t_sum > STOP_W'(64)) ? STOP_W'(64) : t_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_r <= STOP_W'(8);
      new_r <= STOP_W'(8);
    end else if (cfg_we) begin
      if (cfg_addr == REG_OLD_STOP) old_r <= cfg_wdata;
      if (cfg_addr == REG_NEW_STOP) new_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    purp_nxt      = purp_r;
    mode_nxt      = mode_r;
    col_nxt       = col_r;
    pend_nxt      = pend_r;
    qchar_nxt     = qchar_r;
    esc_nxt       = esc_r;
    char_nxt      = char_r;
    has_char_nxt  = has_char_r;
    upd_col_nxt   = upd_col_r;
    b_nxt         = b_r;
    a_nxt         = a_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    mod_req.start   = 1'b0;
    mod_req.divisor = nt;
    mod_dividend    = col_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          esc_nxt     = !esc_r && (c_in == CH_BS);
          char_nxt    = c_in;
          upd_col_nxt = 1'b1;
          if (m_eff == MODE_QUOTE) begin
            has_char_nxt = 1'b1;
            if (c_in == CH_NL && !esc_r) mode_nxt = MODE_NORMAL;
            if (is_quote && !esc_r && c_in == qchar_r) mode_nxt = MODE_NORMAL;
            if (c_in == CH_TAB) begin
              // column moves to next new stop, character passes as is
              mod_req.start = 1'b1;
              purp_nxt      = P_QTAB;
              state_nxt     = S_MOD;
            end else begin
              state_nxt = S_CHAR;
            end
          end else if (c_in == CH_SP || c_in == CH_TAB) begin
            mode_nxt = MODE_BLANK;
            p_nxt    = p_in;
            if (c_in == CH_TAB) begin
              mod_req.start   = 1'b1;
              mod_req.divisor = os;
              mod_dividend    = col_r + COLUMN_BITS'(p_in);
              purp_nxt        = P_BTAB;
              state_nxt       = S_MOD;
            end else begin
              a_nxt     = STOP_W'(1);
              state_nxt = S_BLANK;
            end
          end else begin
            has_char_nxt = 1'b1;
            if (is_quote) begin
              qchar_nxt = c_in;
              mode_nxt  = MODE_QUOTE;
            end else begin
              mode_nxt = MODE_NORMAL;
            end
            if (m_eff == MODE_BLANK) begin
              b_nxt     = {1'b0, pend_r};
              pend_nxt  = 6'd0;
              state_nxt = S_RUN;
            end else begin
              state_nxt = S_CHAR;
            end
          end
        end
      end

      S_MOD: begin
        if (mod_rsp.done) begin
          case (purp_r)
            P_QTAB: begin
              col_nxt     = col_r + COLUMN_BITS'(nt - {1'b0, mod_rsp.rem});
              upd_col_nxt = 1'b0;
              state_nxt   = S_CHAR;
            end
            P_BTAB: begin
              a_nxt     = os - {1'b0, mod_rsp.rem};
              state_nxt = S_BLANK;
            end
            default: begin
              j_nxt     = nt - {1'b0, mod_rsp.rem};
              state_nxt = S_TAB;
            end
          endcase
        end
      end

      S_BLANK: begin
        if (t_sum >= STOP_W'(MAX_RUN)) begin
          // long run: flush up to 64 columns now, keep the rest pending
          b_nxt        = e_run;
          pend_nxt     = 6'(t_sum - e_run);
          has_char_nxt = 1'b0;
          state_nxt    = S_RUN;
        end else begin
          pend_nxt  = t_sum[5:0];
          state_nxt = S_IDLE;
        end
      end

      S_RUN: begin
        if (b_r > STOP_W'(1) && nt > STOP_W'(1)) begin
          mod_req.start = 1'b1;
          purp_nxt      = P_RUN;
          state_nxt     = S_MOD;
        end else begin
          state_nxt = S_SPACE;
        end
      end

      S_TAB: begin
        if (j_r > b_r) begin
          state_nxt = S_SPACE;
        end else if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_TAB;
          out_last_nxt  = (b_r == j_r) && !has_char_r;
          col_nxt       = col_r + COLUMN_BITS'(j_r);
          b_nxt         = b_r - j_r;
          if (b_r == j_r) begin
            state_nxt = S_SPACE;
          end else begin
            // column may wrap, so the next stop distance is recomputed
            mod_req.start = 1'b1;
            mod_dividend  = col_nxt;
            state_nxt     = S_MOD;
          end
        end
      end

      S_SPACE: begin
        if (b_r == '0) begin
          state_nxt = has_char_r ? S_CHAR : S_IDLE;
        end else if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_SP;
          out_last_nxt  = (b_r == STOP_W'(1)) && !has_char_r;
          col_nxt       = col_r + COLUMN_BITS'(1);
          b_nxt         = b_r - STOP_W'(1);
        end
      end

      S_CHAR: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = char_r;
          out_last_nxt  = 1'b1;
          if (upd_col_r) col_nxt = (char_r == CH_NL) ? '0 : col_r + COLUMN_BITS'(1);
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_NORMAL;
      col_r       <= '0;
      pend_r      <= '0;
      qchar_r     <= '0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      col_r       <= col_nxt;
      pend_r      <= pend_nxt;
      qchar_r     <= qchar_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    purp_r     <= purp_nxt;
    char_r     <= char_nxt;
    has_char_r <= has_char_nxt;
    upd_col_r  <= upd_col_nxt;
    b_r        <= b_nxt;
    a_r        <= a_nxt;
    p_r        <= p_nxt;
    j_r        <= j_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // shared remainder unit: column modulo old or new stop
  tsr_mod #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mod_req),
    .dividend (mod_dividend),
    .rsp      (mod_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/tsr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks on the retabulator, bound to the top level.
// ----------------------------------------------------------------------------
module tsr_checker
  import tsr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed under stall");

  // one item at a time: busy right after an input transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // results before the last of an item are only tabs or spaces
  a_run_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[6:0] == CH_TAB || out_tdata[6:0] == CH_SP)
    else $error("non-blank result before end of item");

  // an item is not finished while a non-final result waits
  a_open_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("ready with item results outstanding");

  // results only come from a busy sequencer
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without work in progress");

endmodule

bind tab_stop_retabulator tsr_checker u_tsr_checker (.*);
